>>> hdl/multi_rate_software_timer_bank_assert.svh
// assertion macros for the timer bank checker
// expects clk and arst_n in scope where the macros are used
`ifndef MULTI_RATE_SOFTWARE_TIMER_BANK_ASSERT_SVH
`define MULTI_RATE_SOFTWARE_TIMER_BANK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MRSTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define MRSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mrstb_pkg.sv
// shared types and constants for the multi-rate timer bank
// no dependencies; imported by the top level and its checker
package mrstb_pkg;

	localparam int ACTION_W     = 2;
	localparam int CLASS_W      = 3;
	localparam int INDEX_W      = 3;
	localparam int DATA_W       = 32;
	localparam int RATIO_W      = 16;
	localparam int PRESCALERS   = 4;
	localparam int RATE_CLASSES = PRESCALERS + 1;
	localparam int REG_IDX_W    = 2;

	typedef logic [RATIO_W-1:0] ratio_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_READ = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	// ratio register values after reset, first to fourth class
	localparam ratio_t RATIO_RESET [PRESCALERS] = '{16'd10, 16'd100, 16'd1000, 16'd10000};

endpackage

>>> hdl/multi_rate_software_timer_bank.sv
// multi-rate tick divider with a bank of down-counting timers
// depends on mrstb_pkg
//
// usage
//  - input channel (in_valid / in_stall): one item per transfer, the action
//    selects a base tick, a timer load or a timer read
//  - output channel (out_valid / out_stall): exactly one result per item, in order
//  - write port (wr_en / wr_index / wr_data): ratio registers of the four
//    prescaled classes, to be written only while the block is idle (unchecked)
// timing
//  - an item is captured in an input register, processed in one pass of
//    logic, and its result is written to the output register when that
//    register is free or is being emptied in the same cycle
//  - one item per cycle while out_stall is low; every timer is its own down
//    counter, so all banks count in the same cycle and nothing iterates
// reset
//  - ratios return to 10, 100, 1000, 10000; prescalers and all timers clear,
//    so every timer starts expired
// back-pressure
//  - the output register holds its result while out_stall is high; one more
//    item may wait in the input register, then in_stall rises
module multi_rate_software_timer_bank #(
	parameter int TIMERS_PER_RATE = 8,
	parameter int TIMER_WIDTH     = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  wr_en,
	input  logic [mrstb_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [mrstb_pkg::RATIO_W-1:0]         wr_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mrstb_pkg::ACTION_W-1:0]        action,
	input  logic [mrstb_pkg::CLASS_W-1:0]         rate_class,
	input  logic [mrstb_pkg::INDEX_W-1:0]         timer_index,
	input  logic [mrstb_pkg::DATA_W-1:0]          load_value,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mrstb_pkg::RATE_CLASSES-1:0]    fired_flags,
	output logic [mrstb_pkg::DATA_W-1:0]          read_value,
	output logic                                  timer_expired
);
	import mrstb_pkg::*;

	localparam int IDX_W = (TIMERS_PER_RATE > 1) ? $clog2(TIMERS_PER_RATE) : 1;

	// input register
	logic                     valid_s1;
	action_t                  action_s1;
	logic [CLASS_W-1:0]       rate_class_s1;
	logic [INDEX_W-1:0]       timer_index_s1;
	logic [TIMER_WIDTH-1:0]   load_s1;

	// output register
	logic                     out_valid_q;
	logic [RATE_CLASSES-1:0]  fired_q;
	logic [DATA_W-1:0]        read_q;
	logic                     expired_q;

	// state
	ratio_t                   ratio_q    [PRESCALERS];
	ratio_t                   prescale_q [PRESCALERS];
	logic [TIMER_WIDTH-1:0]   timer_q    [RATE_CLASSES][TIMERS_PER_RATE];

	// datapath signals
	logic                     advance;
	logic                     accept_in;
	logic                     is_tick;
	ratio_t                   cnt_inc    [PRESCALERS];
	logic [PRESCALERS-1:0]    fire;
	logic [RATE_CLASSES-1:0]  class_fire;
	logic                     slot_ok;
	logic [IDX_W-1:0]         idx_sel;
	logic [TIMER_WIDTH-1:0]   rd_word;

	// handshake: the input register moves on when the output register is free
	// or is being emptied in this same cycle
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	assign is_tick = (action_s1 == ACT_TICK);

	// prescalers: count up, fire and clear once the ratio is reached;
	// a zero ratio fires on every base tick
	always_comb begin
		for (int i = 0; i < PRESCALERS; i++) begin
			cnt_inc[i] = prescale_q[i] + 1'b1;
			fire[i]    = (cnt_inc[i] >= ratio_q[i]);
		end
	end

	// base class fires on every tick
	assign class_fire = {fire, 1'b1};

	// addressed timer, guarded against class and index out of range
	assign slot_ok = (rate_class_s1 < CLASS_W'(RATE_CLASSES)) &&
		(32'(timer_index_s1) < 32'(TIMERS_PER_RATE));
	assign idx_sel = IDX_W'(timer_index_s1);
	assign rd_word = slot_ok ? timer_q[rate_class_s1][idx_sel] : '0;

	// input register capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			action_s1      <= action_t'(action);
			rate_class_s1  <= rate_class;
			timer_index_s1 <= timer_index;
			load_s1        <= load_value[TIMER_WIDTH-1:0];
		end
	end

	// ratio registers; the full write data is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRESCALERS; i++)
				ratio_q[i] <= RATIO_RESET[i];
		end else if (wr_en) begin
			ratio_q[wr_index] <= wr_data;
		end
	end

	// prescale counters move only on a base tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRESCALERS; i++)
				prescale_q[i] <= '0;
		end else if (advance && is_tick) begin
			for (int i = 0; i < PRESCALERS; i++)
				prescale_q[i] <= fire[i] ? '0 : cnt_inc[i];
		end
	end

	// timer cells: each one decrements when its class fires and stops at zero,
	// or takes the load value when addressed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < RATE_CLASSES; c++)
				for (int k = 0; k < TIMERS_PER_RATE; k++)
					timer_q[c][k] <= '0;
		end else if (advance) begin
			for (int c = 0; c < RATE_CLASSES; c++) begin
				for (int k = 0; k < TIMERS_PER_RATE; k++) begin
					if (is_tick && class_fire[c] && (timer_q[c][k] != '0)) begin
						timer_q[c][k] <= timer_q[c][k] - 1'b1;
					end else if ((action_s1 == ACT_LOAD) && slot_ok &&
						(rate_class_s1 == CLASS_W'(c)) && (idx_sel == IDX_W'(k))) begin
						timer_q[c][k] <= load_s1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fired_q   <= is_tick ? class_fire : '0;
			read_q    <= (action_s1 == ACT_READ) ? DATA_W'(rd_word) : '0;
			expired_q <= (action_s1 == ACT_READ) && slot_ok && (rd_word == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign fired_flags   = fired_q;
	assign read_value    = read_q;
	assign timer_expired = expired_q;

endmodule

>>> hdl/mrstb_checker.sv
// port-level checker for the multi-rate timer bank, bound to the top level
// depends on mrstb_pkg and multi_rate_software_timer_bank_assert.svh
`include "multi_rate_software_timer_bank_assert.svh"

module mrstb_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [mrstb_pkg::RATE_CLASSES-1:0]   fired_flags,
	input logic [mrstb_pkg::DATA_W-1:0]         read_value,
	input logic                                 timer_expired
);
	import mrstb_pkg::*;

	// any tick result has the base class set
	`MRSTB_ASSERT(a_tick_has_base, out_valid && (fired_flags != '0) |-> fired_flags[0], "class fired without base tick")

	// an expired timer reads zero
	`MRSTB_ASSERT(a_expired_is_zero, out_valid && timer_expired |-> (read_value == '0), "expired timer with nonzero count")

	// read data and tick flags never share a result
	`MRSTB_ASSERT(a_read_not_tick, out_valid && ((read_value != '0) || timer_expired) |-> (fired_flags == '0), "read result carries fired flags")

	// input back-pressure only comes from a blocked output
	`MRSTB_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled while output free")

	// a stalled result holds
	`MRSTB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value) && $stable(fired_flags) && $stable(timer_expired), "stalled result changed")

endmodule

bind multi_rate_software_timer_bank mrstb_checker u_mrstb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.fired_flags   (fired_flags),
	.read_value    (read_value),
	.timer_expired (timer_expired)
);
